// ===== rtl/tsh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsh_pkg: shared constants, types and trit helpers
// Trit coding, item kinds, walk constants and the pair-mixing table of the
// ternary sponge permutation.
// ----------------------------------------------------------------------------
package tsh_pkg;

   localparam int STATE_TRITS     = 729;
   localparam int DEF_RATE_TRITS  = 243;
   localparam int DEF_ROUND_COUNT = 81;
   localparam int ADDR_W          = $clog2(STATE_TRITS);
   localparam int TRIT_W          = 2;
   localparam int KIND_W          = 2;

   typedef logic [TRIT_W-1:0] trit_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [KIND_W-1:0] kind_type;

   // balanced trit, two's complement
   localparam trit_type TRIT_ZERO = 2'b00;
   localparam trit_type TRIT_POS  = 2'b01;
   localparam trit_type TRIT_BAD  = 2'b10;
   localparam trit_type TRIT_NEG  = 2'b11;

   // item kinds
   localparam kind_type KIND_ABSORB  = 2'd0;
   localparam kind_type KIND_SQUEEZE = 2'd1;
   localparam kind_type KIND_CLEAR   = 2'd2;

   // walk over the state copy
   localparam addr_type WALK_SPLIT = ADDR_W'(365);
   localparam addr_type WALK_UP    = ADDR_W'(364);
   localparam addr_type WALK_DOWN  = ADDR_W'(365);
   localparam addr_type LAST_ADDR  = ADDR_W'(STATE_TRITS - 1);

   // indexed by (a + 1) + 3 * (b + 1)
   localparam trit_type MIX_TABLE [9] = '{
      TRIT_POS, TRIT_ZERO, TRIT_NEG,
      TRIT_POS, TRIT_NEG,  TRIT_ZERO,
      TRIT_NEG, TRIT_POS,  TRIT_ZERO
   };

   // out-of-range pattern saturates to -1
   function automatic trit_type sat_trit(input trit_type t);
      sat_trit = (t == TRIT_BAD) ? TRIT_NEG : t;
   endfunction

   // trit plus one, as a base-3 digit
   function automatic logic [1:0] trit_digit(input trit_type t);
      case (t)
         TRIT_ZERO: trit_digit = 2'd1;
         TRIT_POS:  trit_digit = 2'd2;
         default:   trit_digit = 2'd0;
      endcase
   endfunction

   function automatic trit_type mix_trits(input trit_type a, input trit_type b);
      logic [1:0] da;
      logic [1:0] db;
      logic [3:0] idx;
      da  = trit_digit(a);
      db  = trit_digit(b);
      idx = 4'(da) + 4'({db, 1'b0}) + 4'(db);
      mix_trits = MIX_TABLE[idx];
   endfunction

   function automatic addr_type walk_step(input addr_type w);
      walk_step = (w < WALK_SPLIT) ? (w + WALK_UP) : (w - WALK_DOWN);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tsh_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsh_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tsh_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 729
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/ternary_sponge_hash_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ternary_sponge_hash_unit: ternary sponge hash, one trit per item
// Absorbs and squeezes balanced trits over a 729-trit state held in two
// ping-pong memories, and runs the round permutation out of those memories.
// ----------------------------------------------------------------------------
// Usage and timing: each request item carries one trit action. A squeeze item
// also holds off the next item until its memory read data is back. After
// RATE_TRITS positions, or after an absorb or squeeze item flagged tlast, the
// state is permuted: each round reads the state from one memory and writes the
// new state to the other, one trit per cycle through a single read port. After
// reset and after a clear item the block sweeps the state memory to zero.
// req_tready is low during a permutation or a clearing sweep. A squeezed trit
// can wait on the response side while absorb items continue.
// ----------------------------------------------------------------------------
module ternary_sponge_hash_unit
   import tsh_pkg::*;
#(
   parameter int RATE_TRITS  = DEF_RATE_TRITS,
   parameter int ROUND_COUNT = DEF_ROUND_COUNT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [1:0] trit_in
   input  wire logic [1:0] req_tuser,   // [1:0] action
   input  wire logic       req_tlast,   // last_of_call
   // response channel
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [1:0] trit_out
);

   localparam int POS_W = $clog2(RATE_TRITS + 1);
   localparam int RND_W = $clog2(ROUND_COUNT + 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_PRIME = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_RUN   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   addr_type         walk_ff, walk_in;
   addr_type         step_ff, step_in;    // write index in a round, sweep index
   logic [RND_W-1:0] round_ff, round_in;
   logic             bank_ff, bank_in;    // memory holding the live state
   trit_type         prev_ff, prev_in;    // copy trit at the previous walk index

   logic             sqz_data_ff, sqz_data_in;
   logic             pend_valid_ff, pend_valid_in;
   trit_type         pend_trit_ff, pend_trit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   trit_type         rsp_trit_ff, rsp_trit_in;

   // memory ports (shared address, per-bank write enable)
   logic             wr_live, wr_other;
   addr_type         wr_addr, rd_addr;
   trit_type         wr_data;
   trit_type         rd_data0, rd_data1, rd_data;

   logic             accept;
   kind_type         kind;
   logic [POS_W-1:0] pos_inc;
   addr_type         walk_next;
   logic             slot_free;

   assign kind      = req_tuser;
   assign accept    = req_tvalid && req_tready;
   assign pos_inc   = pos_ff + POS_W'(1);
   assign walk_next = walk_step(walk_ff);
   assign rd_data   = bank_ff ? rd_data1 : rd_data0;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // one squeeze in flight at most; its read data needs a free slot or the pend
   assign req_tready = (state_ff == ST_IDLE) && !pend_valid_ff && !sqz_data_ff;

   // ------------------------------------------------------------------------
   // sequencer: items, clearing sweep, permutation rounds
   // ------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      walk_in     = walk_ff;
      step_in     = step_ff;
      round_in    = round_ff;
      bank_in     = bank_ff;
      prev_in     = prev_ff;
      sqz_data_in = 1'b0;
      wr_live     = 1'b0;
      wr_other    = 1'b0;
      wr_addr     = step_ff;
      wr_data     = TRIT_ZERO;
      rd_addr     = walk_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (kind == KIND_CLEAR) begin
                  pos_in   = '0;
                  step_in  = '0;
                  state_in = ST_CLEAR;
               end else if (kind == KIND_ABSORB || kind == KIND_SQUEEZE) begin
                  wr_addr = ADDR_W'(pos_ff);
                  rd_addr = ADDR_W'(pos_ff);
                  wr_data = sat_trit(trit_type'(req_tdata[TRIT_W-1:0]));
                  if (kind == KIND_ABSORB) begin
                     wr_live = 1'b1;
                  end else begin
                     sqz_data_in = 1'b1;
                  end
                  // end of block or of call: permute
                  if (req_tlast || pos_inc >= POS_W'(RATE_TRITS)) begin
                     pos_in   = '0;
                     walk_in  = '0;
                     round_in = '0;
                     state_in = ST_PRIME;
                  end else begin
                     pos_in = pos_inc;
                  end
               end
            end
         end
         ST_CLEAR: begin
            wr_live = 1'b1;
            step_in = step_ff + ADDR_W'(1);
            if (step_ff == LAST_ADDR) begin
               step_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_PRIME: begin
            // fetch the trit at the walk's start for this round
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            prev_in  = rd_data;
            rd_addr  = walk_next;
            walk_in  = walk_next;
            step_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            wr_other = 1'b1;
            wr_data  = mix_trits(prev_ff, rd_data);
            prev_in  = rd_data;
            if (step_ff == LAST_ADDR) begin
               step_in = '0;
               bank_in = !bank_ff;
               if (round_ff == RND_W'(ROUND_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  round_in = round_ff + RND_W'(1);
                  state_in = ST_PRIME;
               end
            end else begin
               rd_addr = walk_next;
               walk_in = walk_next;
               step_in = step_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // response side: output register plus one pending trit
   // ------------------------------------------------------------------------
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_trit_in  = pend_trit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_trit_in   = rsp_trit_ff;
      if (sqz_data_ff) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_trit_in  = rd_data;
         end else begin
            pend_valid_in = 1'b1;
            pend_trit_in  = rd_data;
         end
      end else if (pend_valid_ff && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_trit_in   = pend_trit_ff;
         pend_valid_in = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pos_ff        <= '0;
         walk_ff       <= '0;
         step_ff       <= '0;
         round_ff      <= '0;
         bank_ff       <= 1'b0;
         sqz_data_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         walk_ff       <= walk_in;
         step_ff       <= step_in;
         round_ff      <= round_in;
         bank_ff       <= bank_in;
         sqz_data_ff   <= sqz_data_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff      <= prev_in;
      pend_trit_ff <= pend_trit_in;
      rsp_trit_ff  <= rsp_trit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_trit_ff};

   // ------------------------------------------------------------------------
   // state memories, ping-pong per round
   // ------------------------------------------------------------------------
   tsh_ram #(
      .WIDTH (TRIT_W),
      .DEPTH (STATE_TRITS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (bank_ff ? wr_other : wr_live),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   tsh_ram #(
      .WIDTH (TRIT_W),
      .DEPTH (STATE_TRITS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (bank_ff ? wr_live : wr_other),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

`ifndef SYNTHESIS
   // a pending trit exists only behind a full output register
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending trit without a held response");

   // squeeze read data never arrives while a trit is already pending
   assert property (@(posedge clock) disable iff (reset)
      !(sqz_data_ff && pend_valid_ff))
      else $error("squeeze data collides with pending trit");

   // walk index stays inside the state
   assert property (@(posedge clock) disable iff (reset)
      walk_ff <= LAST_ADDR)
      else $error("walk index out of range");

   // block position stays inside the rate block
   assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(RATE_TRITS))
      else $error("block position out of range");
`endif

endmodule
`default_nettype wire

// ===== bench/ternary_sponge_hash_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ternary_sponge_hash_unit_tb: self-checking bench for the ternary sponge hash
// Sends absorb, squeeze and clear items through the request stream. A model of
// the sponge state runs beside the block, and each squeezed trit is checked in
// order. The sender idles between bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module ternary_sponge_hash_unit_tb;
   import tsh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Default rate and round count, as the block is normally built.
   localparam int TB_RATE   = DEF_RATE_TRITS;
   localparam int TB_ROUNDS = DEF_ROUND_COUNT;
   localparam int ITEM_GOAL = 1300;

   // action code that the block ignores
   localparam kind_type KIND_UNUSED = 2'd3;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the sponge and the squeezed trits due
   // -------------------------------------------------------------------------
   class sponge_scoreboard #(int RATE = 243, int ROUNDS = 2);
      localparam int WALK_TURN = 365;
      localparam int WALK_FWD  = 364;
      localparam int WALK_BACK = 365;

      trit_type    sponge[STATE_TRITS];
      trit_type    round_snap[STATE_TRITS];
      int unsigned block_pos;
      int          pair_map[9];
      trit_type    squeezed_trits[$];
      int unsigned mismatches;

      function new();
         pair_map   = '{1, 0, -1, 1, -1, 0, -1, 1, 0};
         mismatches = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (sponge[i]) sponge[i] = TRIT_ZERO;
         block_pos = 0;
      endfunction

      function int trit_value(trit_type t);
         if (t == TRIT_POS) return 1;
         if (t == TRIT_ZERO) return 0;
         return -1;
      endfunction

      function trit_type to_trit(int v);
         if (v > 0) return TRIT_POS;
         if (v < 0) return TRIT_NEG;
         return TRIT_ZERO;
      endfunction

      // walk index runs on across all rounds of one permutation
      function void permute();
         int unsigned walk;
         int unsigned prev;
         walk = 0;
         for (int r = 0; r < ROUNDS; r++) begin
            round_snap = sponge;
            for (int k = 0; k < STATE_TRITS; k++) begin
               prev = walk;
               walk = (walk < WALK_TURN) ? walk + WALK_FWD : walk - WALK_BACK;
               sponge[k] = to_trit(pair_map[trit_value(round_snap[prev])
                                            + 3 * trit_value(round_snap[walk]) + 4]);
            end
         end
      endfunction

      function void step_position(bit last);
         block_pos++;
         if (block_pos >= RATE || block_pos >= STATE_TRITS || last) begin
            permute();
            block_pos = 0;
         end
      endfunction

      function void accept_item(kind_type kind, trit_type t, bit last);
         case (kind)
            KIND_ABSORB: begin
               // out-of-range pattern saturates to minus one
               sponge[block_pos] = (t == TRIT_BAD) ? TRIT_NEG : t;
               step_position(last);
            end
            KIND_SQUEEZE: begin
               squeezed_trits.push_back(sponge[block_pos]);
               step_position(last);
            end
            KIND_CLEAR: wipe();
            default: ;
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_squeezed(trit_type got);
         trit_type want;
         if (squeezed_trits.size() == 0) begin
            report_mismatch($sformatf("trit_out %b with no squeeze pending", got));
         end else begin
            want = squeezed_trits.pop_front();
            if (got !== want)
               report_mismatch($sformatf("trit_out %b, expected %b", got, want));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block and its ports
   // -------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [1:0] trit_in
   logic [1:0] req_tuser = '0;    // [1:0] action
   logic       req_tlast = 1'b0;  // last_of_call
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [1:0] trit_out

   ternary_sponge_hash_unit #(
      .RATE_TRITS  (TB_RATE),
      .ROUND_COUNT (TB_ROUNDS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sponge_scoreboard #(.RATE(TB_RATE), .ROUNDS(TB_ROUNDS)) sb;

   int unsigned items_sent = 0;   // absorb, squeeze and clear items accepted
   int unsigned burst_left = 0;   // items left in the current sender burst
   int unsigned stall_left = 0;
   int unsigned stall_mode = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Both handshakes are sampled at the edge, before this edge's updates land.
   // The input side is noted first, so a squeeze is always queued before its
   // trit could be checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.accept_item(req_tuser, req_tdata[1:0], req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_squeezed(rsp_tdata[1:0]);
      end
   end

   // Receiver: always ready, coin-flip ready, or mostly stalled, for stretches
   // of random length.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(16, 160);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // One item through the request channel. Between bursts tvalid drops for a
   // random gap; inside a burst it stays high from item to item.
   task automatic send_item(input kind_type kind, input trit_type t, input bit last);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, t};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   // Hold off the sender until every squeezed trit has come back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.squeezed_trits.size() != 0) @(posedge clock);
   endtask

   function automatic trit_type any_pattern();
      return trit_type'($urandom_range(0, 3));
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned pick;
      int unsigned len;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: squeeze the reset state, every trit pattern including the
      // saturating one, the ignored action code with tlast set, clear in the
      // middle of a call and with tlast set, and squeezes that carry a trit.
      send_item(KIND_SQUEEZE, TRIT_ZERO, 1'b0);
      send_item(KIND_ABSORB,  TRIT_POS,  1'b0);
      send_item(KIND_ABSORB,  TRIT_NEG,  1'b0);
      send_item(KIND_ABSORB,  TRIT_BAD,  1'b0);
      send_item(KIND_UNUSED,  TRIT_POS,  1'b1);
      send_item(KIND_ABSORB,  TRIT_ZERO, 1'b1);
      send_item(KIND_SQUEEZE, TRIT_NEG,  1'b0);
      send_item(KIND_SQUEEZE, TRIT_BAD,  1'b0);
      send_item(KIND_SQUEEZE, TRIT_ZERO, 1'b1);
      send_item(KIND_ABSORB,  TRIT_POS,  1'b0);
      send_item(KIND_ABSORB,  TRIT_POS,  1'b0);
      send_item(KIND_CLEAR,   TRIT_NEG,  1'b0);
      send_item(KIND_SQUEEZE, TRIT_ZERO, 1'b1);
      send_item(KIND_SQUEEZE, TRIT_POS,  1'b0);
      send_item(KIND_CLEAR,   TRIT_BAD,  1'b1);
      send_item(KIND_SQUEEZE, TRIT_ZERO, 1'b0);
      send_item(KIND_ABSORB,  TRIT_BAD,  1'b1);
      send_item(KIND_UNUSED,  TRIT_BAD,  1'b0);
      send_item(KIND_SQUEEZE, TRIT_ZERO, 1'b0);
      send_item(KIND_SQUEEZE, TRIT_ZERO, 1'b1);
      pause_until_drained();

      // Random: mostly absorb calls followed by squeeze calls, some of them
      // long enough to cross the rate boundary, plus broken calls without
      // tlast, single noise items and clears after a full drain.
      while (items_sent < ITEM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 300)
                                              : $urandom_range(4, 40);
            for (int i = 0; i < len; i++)
               send_item(KIND_ABSORB, any_pattern(), i == len - 1);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 260)
                                               : $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
               send_item(KIND_SQUEEZE, any_pattern(), i == len - 1);
         end else if (pick < 85) begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
               send_item(kind_type'($urandom_range(0, 1)), any_pattern(), 1'b0);
         end else if (pick < 95) begin
            send_item(kind_type'($urandom_range(0, 3)), any_pattern(),
                      $urandom_range(0, 3) == 0);
         end else begin
            pause_until_drained();
            send_item(KIND_CLEAR, any_pattern(), 1'($urandom_range(0, 1)));
         end
      end

      // Drain: every squeezed trit back, then a short tail for strays.
      pause_until_drained();
      repeat (50) @(posedge clock);
      if (sb.squeezed_trits.size() != 0)
         sb.report_mismatch($sformatf("%0d squeezed trits never returned",
                                      sb.squeezed_trits.size()));
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run of this stimulus.
   initial begin
      #1_000_000_000;
      $display("timeout: block stopped making progress");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/tsh_pkg.sv
rtl/tsh_ram.sv
rtl/ternary_sponge_hash_unit.sv
bench/ternary_sponge_hash_unit_tb.sv
